// ----- src/mlsq_pkg.sv -----
`timescale 1ns / 1ps

package mlsq_pkg;

	// Sizing of the process table and of the priority levels
	localparam int SLOTS = 16;
	localparam int LEVELS = 4;
	localparam int ID_BITS = 16;

	// Field widths of the channels
	localparam int ID_PORT_W = 16;
	localparam int LVL_PORT_W = 2;
	localparam int SLOT_PORT_W = 4;

	// Derived widths of the stored values
	localparam int STORE_W = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int LVL_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	// Depth of the queues on both sides of the execution unit
	localparam int QD = 2;
	localparam int QP = (QD > 1) ? $clog2(QD) : 1;
	localparam int QC = $clog2(QD + 1);

	typedef enum logic [1:0] {
		CMD_ENQUEUE  = 2'd0,
		CMD_DISPATCH = 2'd1,
		CMD_REMOVE   = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TABLE_FULL = 3'd1,
		ST_LEVEL_FULL = 3'd2,
		ST_NONE_READY = 3'd3,
		ST_NOT_FOUND  = 3'd4,
		ST_BAD_ID     = 3'd5
	} status_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	// Classified command as it waits for the execution unit
	typedef struct packed {
		cmd_t                cmd;
		logic [STORE_W-1:0]  id;
		logic [LVL_BITS-1:0] lvl;
	} cmd_item_t;

	// One result beat
	typedef struct packed {
		status_t                status;
		logic [ID_PORT_W-1:0]   granted_id;
		logic [LVL_PORT_W-1:0]  granted_level;
		logic [SLOT_PORT_W-1:0] table_slot;
	} result_t;

	// Lowest set bit of a slot vector
	function automatic logic [SLOT_BITS:0] first_slot(input logic [SLOTS-1:0] v);
		logic [SLOT_BITS:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, SLOT_BITS'(i)};
			end
		end
		return r;
	endfunction

	// Lowest set bit of a level vector
	function automatic logic [LVL_BITS:0] first_level(input logic [LEVELS-1:0] v);
		logic [LVL_BITS:0] r;
		r = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, LVL_BITS'(i)};
			end
		end
		return r;
	endfunction

endpackage

// ----- src/mlsq_front.sv -----
`timescale 1ns / 1ps

module mlsq_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                command,
	input  logic [mlsq_pkg::ID_PORT_W-1:0]  process_id,
	input  logic [mlsq_pkg::LVL_PORT_W-1:0] level,
	output logic                      head_valid,
	output mlsq_pkg::cmd_item_t       head,
	input  logic                      head_take
);
	import mlsq_pkg::*;

	cmd_item_t       mem_q [QD];
	logic [QP-1:0]   wr_ptr_q;
	logic [QP-1:0]   rd_ptr_q;
	logic [QC-1:0]   count_q;
	cmd_item_t       item;
	logic            do_push;
	logic            do_pop;

	// Classify the incoming beat: mask the id, saturate the level
	always_comb begin
		item.cmd = cmd_t'(command);
		item.id = process_id[STORE_W-1:0];
		if (32'(level) > 32'(LEVELS - 1)) begin
			item.lvl = LVL_BITS'(LEVELS - 1);
		end else begin
			item.lvl = LVL_BITS'(level);
		end
	end

	assign full = (count_q == QC'(QD));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = head_take && head_valid;

	// Store the classified command
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QD - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QD - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/mlsq_back.sv -----
`timescale 1ns / 1ps

module mlsq_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  mlsq_pkg::cmd_item_t head,
	output logic                head_take,
	input  logic                res_full,
	output logic                res_push,
	output mlsq_pkg::result_t   res
);
	import mlsq_pkg::*;

	back_state_t         state_q;
	back_state_t         state_d;

	// Process table and level rows
	logic [STORE_W-1:0]  table_q [SLOTS];
	logic [STORE_W-1:0]  row_q   [LEVELS][SLOTS];

	// Match vectors and command held for the execute cycle
	cmd_item_t           cmd_s1;
	logic [SLOTS-1:0]    tfree_s1;
	logic [SLOTS-1:0]    thit_s1;
	logic [SLOTS-1:0]    lfree_s1 [LEVELS];
	logic [SLOTS-1:0]    lhit_s1  [LEVELS];

	logic [SLOT_BITS:0]  t_free_enc;
	logic [SLOT_BITS:0]  t_hit_enc;
	logic [SLOT_BITS:0]  q_free_enc;
	logic [LEVELS-1:0]   lvl_busy;
	logic [LVL_BITS:0]   disp_lvl_enc;
	logic [SLOT_BITS:0]  disp_slot_enc;
	logic [SLOT_BITS:0]  rm_enc [LEVELS];

	logic                do_enq;
	logic                do_disp;
	logic                do_rm;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Take a command when a result slot is free, execute it in the cycle after
	always_comb begin
		state_d = state_q;
		head_take = 1'b0;
		res_push = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (head_valid && !res_full) begin
					head_take = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				res_push = 1'b1;
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Compare every stored entry against zero and the command's id
	always_ff @(posedge clk) begin
		if (head_take) begin
			cmd_s1 <= head;
			for (int i = 0; i < SLOTS; i++) begin
				tfree_s1[i] <= (table_q[i] == '0);
				thit_s1[i] <= (table_q[i] == head.id);
			end
			for (int l = 0; l < LEVELS; l++) begin
				for (int i = 0; i < SLOTS; i++) begin
					lfree_s1[l][i] <= (row_q[l][i] == '0);
					lhit_s1[l][i] <= (row_q[l][i] == head.id);
				end
			end
		end
	end

	// Encode the registered match vectors
	always_comb begin
		t_free_enc = first_slot(tfree_s1);
		t_hit_enc = first_slot(thit_s1);
		q_free_enc = first_slot(lfree_s1[cmd_s1.lvl]);
		for (int l = 0; l < LEVELS; l++) begin
			lvl_busy[l] = ~&lfree_s1[l];
			rm_enc[l] = first_slot(lhit_s1[l]);
		end
		disp_lvl_enc = first_level(lvl_busy);
		disp_slot_enc = first_slot(~lfree_s1[disp_lvl_enc[LVL_BITS-1:0]]);
	end

	// Decide the outcome and build the result beat
	always_comb begin
		logic [31:0] slot_w;
		logic [31:0] lvl_w;
		slot_w = '0;
		lvl_w = '0;
		do_enq = 1'b0;
		do_disp = 1'b0;
		do_rm = 1'b0;
		res.status = ST_OK;
		res.granted_id = '0;
		res.granted_level = '0;
		res.table_slot = '0;
		case (cmd_s1.cmd)
			CMD_ENQUEUE: begin
				if (cmd_s1.id == '0) begin
					res.status = ST_BAD_ID;
				end else if (!t_free_enc[SLOT_BITS]) begin
					res.status = ST_TABLE_FULL;
				end else if (!q_free_enc[SLOT_BITS]) begin
					res.status = ST_LEVEL_FULL;
				end else begin
					do_enq = 1'b1;
					slot_w = 32'(t_free_enc[SLOT_BITS-1:0]);
					res.table_slot = slot_w[SLOT_PORT_W-1:0];
				end
			end
			CMD_DISPATCH: begin
				if (!disp_lvl_enc[LVL_BITS]) begin
					res.status = ST_NONE_READY;
				end else begin
					do_disp = 1'b1;
					lvl_w = 32'(disp_lvl_enc[LVL_BITS-1:0]);
					res.granted_level = lvl_w[LVL_PORT_W-1:0];
					res.granted_id = ID_PORT_W'(row_q[disp_lvl_enc[LVL_BITS-1:0]]
						[disp_slot_enc[SLOT_BITS-1:0]]);
				end
			end
			CMD_REMOVE: begin
				if (cmd_s1.id == '0) begin
					res.status = ST_BAD_ID;
				end else if (!t_hit_enc[SLOT_BITS]) begin
					res.status = ST_NOT_FOUND;
				end else begin
					do_rm = 1'b1;
					slot_w = 32'(t_hit_enc[SLOT_BITS-1:0]);
					res.table_slot = slot_w[SLOT_PORT_W-1:0];
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

	// Update the table and the level rows at the end of the execute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				table_q[i] <= '0;
			end
			for (int l = 0; l < LEVELS; l++) begin
				for (int i = 0; i < SLOTS; i++) begin
					row_q[l][i] <= '0;
				end
			end
		end else if (state_q == BK_EXEC) begin
			if (do_enq) begin
				table_q[t_free_enc[SLOT_BITS-1:0]] <= cmd_s1.id;
				row_q[cmd_s1.lvl][q_free_enc[SLOT_BITS-1:0]] <= cmd_s1.id;
			end
			if (do_disp) begin
				row_q[disp_lvl_enc[LVL_BITS-1:0]][disp_slot_enc[SLOT_BITS-1:0]] <= '0;
			end
			if (do_rm) begin
				table_q[t_hit_enc[SLOT_BITS-1:0]] <= '0;
				for (int l = 0; l < LEVELS; l++) begin
					if (rm_enc[l][SLOT_BITS]) begin
						row_q[l][rm_enc[l][SLOT_BITS-1:0]] <= '0;
					end
				end
			end
		end
	end

endmodule

// ----- src/mlsq_resq.sv -----
`timescale 1ns / 1ps

module mlsq_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  mlsq_pkg::result_t wr_data,
	output logic              wr_full,
	output logic              empty,
	input  logic              pop,
	output mlsq_pkg::result_t rd_data
);
	import mlsq_pkg::*;

	result_t        mem_q [QD];
	logic [QP-1:0]  wr_ptr_q;
	logic [QP-1:0]  rd_ptr_q;
	logic [QC-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign wr_full = (count_q == QC'(QD));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_push = wr_en && !wr_full;
	assign do_pop = pop && !empty;

	// Store the result beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QD - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QD - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/multilevel_slot_queue_scheduler.sv -----
`timescale 1ns / 1ps

// Strict-priority scheduler with a process table and four priority levels.
// Input channel: a beat (command, process_id, level) is taken when push is
// high and full is low. Commands: enqueue, dispatch next, remove process.
// Result channel: while empty is low, status, granted_id, granted_level and
// table_slot show the oldest result; it leaves when pop is high.
// Every command gives exactly one result, in command order.
// A two-entry command queue feeds the execution unit, which compares every
// table and level entry against the id into its match registers as it takes
// a command, then in its execute state encodes the matches and updates the
// entries; it takes a new command only once the last one has been executed.
// An accepted beat passes the command queue, the match registers and the result queue.
// When the receiver stalls, results collect in a two-entry result queue; the
// execution unit then waits, the command queue fills and full rises.
// Reset clears both queues, the process table and all level slots at once;
// the block can take a beat as soon as reset is released.
module multilevel_slot_queue_scheduler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [1:0]                       command,
	input  logic [mlsq_pkg::ID_PORT_W-1:0]   process_id,
	input  logic [mlsq_pkg::LVL_PORT_W-1:0]  level,
	output logic                             empty,
	input  logic                             pop,
	output logic [2:0]                       status,
	output logic [mlsq_pkg::ID_PORT_W-1:0]   granted_id,
	output logic [mlsq_pkg::LVL_PORT_W-1:0]  granted_level,
	output logic [mlsq_pkg::SLOT_PORT_W-1:0] table_slot
);
	import mlsq_pkg::*;

	logic       head_valid;
	cmd_item_t  head;
	logic       head_take;
	logic       res_full;
	logic       res_push;
	result_t    res;
	result_t    res_out;

	mlsq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.process_id (process_id),
		.level      (level),
		.head_valid (head_valid),
		.head       (head),
		.head_take  (head_take)
	);

	mlsq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_take  (head_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	mlsq_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.wr_full (res_full),
		.empty   (empty),
		.pop     (pop),
		.rd_data (res_out)
	);

	// Drive the result ports from the queue head
	assign status = res_out.status;
	assign granted_id = res_out.granted_id;
	assign granted_level = res_out.granted_level;
	assign table_slot = res_out.table_slot;

endmodule

// ----- tb/sv/multilevel_slot_queue_scheduler_tb.sv -----
`timescale 1ns / 1ps

module multilevel_slot_queue_scheduler_tb;
	import mlsq_pkg::*;

	localparam int unsigned RAND_ITEMS = 1850;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned TAIL_CYCLES = 16;
	localparam int unsigned IDLE_PCT = 24;
	localparam int unsigned MAX_LINES = 50;

	// One command beat waiting to go out; hold makes the sender wait for a drained block
	typedef struct {
		cmd_t                  op;
		logic [ID_PORT_W-1:0]  pid;
		logic [LVL_PORT_W-1:0] lv;
		bit                    hold;
	} sched_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] command = CMD_NOP;
	logic [ID_PORT_W-1:0] process_id = '0;
	logic [LVL_PORT_W-1:0] level = '0;
	logic empty;
	logic pop = 1'b0;
	logic [2:0] status;
	logic [ID_PORT_W-1:0] granted_id;
	logic [LVL_PORT_W-1:0] granted_level;
	logic [SLOT_PORT_W-1:0] table_slot;

	sched_cmd_t cmd_backlog[$];
	result_t results_due[$];
	result_t head_r;
	logic [ID_PORT_W-1:0] live_ids[$];

	// Scheduler state as the testbench sees it
	logic [STORE_W-1:0] pid_table [SLOTS] = '{default: '0};
	logic [STORE_W-1:0] prio_rows [LEVELS][SLOTS] = '{default: '{default: '0}};

	int unsigned n_taken = 0;
	int unsigned n_seen = 0;
	int unsigned errors = 0;
	int unsigned cyc = 0;
	bit calm;

	multilevel_slot_queue_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.command       (command),
		.process_id    (process_id),
		.level         (level),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.granted_id    (granted_id),
		.granted_level (granted_level),
		.table_slot    (table_slot)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// No idling on either side while this window of commands goes through
	assign calm = (n_taken >= 900) && (n_taken < 1200);

	// Apply one command to the local scheduler state and return its result beat
	function automatic result_t sched_outcome(input cmd_t op, input logic [ID_PORT_W-1:0] pid,
		input logic [LVL_PORT_W-1:0] lv);
		result_t r;
		logic [STORE_W-1:0] key;
		int row;
		int ts;
		int qs;
		bit hit;
		r = '0;
		r.status = ST_OK;
		key = pid[STORE_W-1:0];
		row = (int'(lv) > LEVELS - 1) ? LEVELS - 1 : int'(lv);
		ts = -1;
		qs = -1;
		hit = 1'b0;
		case (op)
			CMD_ENQUEUE: begin
				if (key == '0) begin
					r.status = ST_BAD_ID;
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (ts < 0 && pid_table[i] == '0) ts = i;
					for (int i = 0; i < SLOTS; i++)
						if (qs < 0 && prio_rows[row][i] == '0) qs = i;
					if (ts < 0) begin
						r.status = ST_TABLE_FULL;
					end else if (qs < 0) begin
						r.status = ST_LEVEL_FULL;
					end else begin
						pid_table[ts] = key;
						prio_rows[row][qs] = key;
						r.table_slot = SLOT_PORT_W'(ts);
					end
				end
			end
			CMD_DISPATCH: begin
				// Lowest level first, lowest slot within it
				for (int l = 0; l < LEVELS; l++) begin
					for (int q = 0; q < SLOTS; q++) begin
						if (!hit && prio_rows[l][q] != '0) begin
							hit = 1'b1;
							r.granted_id = ID_PORT_W'(prio_rows[l][q]);
							r.granted_level = LVL_PORT_W'(l);
							prio_rows[l][q] = '0;
						end
					end
				end
				if (!hit) r.status = ST_NONE_READY;
			end
			CMD_REMOVE: begin
				if (key == '0) begin
					r.status = ST_BAD_ID;
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (ts < 0 && pid_table[i] == key) ts = i;
					if (ts < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						pid_table[ts] = '0;
						// Drop the first match in every level
						for (int l = 0; l < LEVELS; l++) begin
							qs = -1;
							for (int q = 0; q < SLOTS; q++)
								if (qs < 0 && prio_rows[l][q] == key) qs = q;
							if (qs >= 0) prio_rows[l][qs] = '0;
						end
						r.table_slot = SLOT_PORT_W'(ts);
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got_v,
		input int unsigned want_v);
		if (errors < MAX_LINES)
			$display("mismatch on %s at result %0d: got %0h, want %0h",
				what, n_seen, got_v, want_v);
		errors++;
	endtask

	task automatic queue_cmd(input cmd_t op, input logic [ID_PORT_W-1:0] pid,
		input logic [LVL_PORT_W-1:0] lv, input bit hold = 1'b0);
		sched_cmd_t c;
		c.op = op;
		c.pid = pid;
		c.lv = lv;
		c.hold = hold;
		cmd_backlog.push_back(c);
	endtask

	function automatic logic [ID_PORT_W-1:0] draw_id();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 3) return '0;
		if (p < 8) return 16'hFFFF;
		if (p < 11) return 16'h0001;
		return ID_PORT_W'($urandom_range(1, 65535));
	endfunction

	// Driver: record accepted beats, then present the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			command <= CMD_NOP;
			process_id <= '0;
			level <= '0;
		end else begin
			if (push && !full) begin
				results_due.push_back(sched_outcome(cmd_t'(command), process_id, level));
				n_taken <= n_taken + 1;
			end
			if (!push || !full) begin
				if (cmd_backlog.size() == 0) begin
					push <= 1'b0;
				end else if (cmd_backlog[0].hold && (push || results_due.size() != 0)) begin
					push <= 1'b0;
				end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
					push <= 1'b0;
				end else begin
					push <= 1'b1;
					command <= cmd_backlog[0].op;
					process_id <= cmd_backlog[0].pid;
					level <= cmd_backlog[0].lv;
					cmd_backlog.pop_front();
				end
			end
		end
	end

	// Monitor: check each popped beat against the oldest expected result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					flag_mismatch("unexpected beat", status, 0);
				end else begin
					head_r = results_due.pop_front();
					if (status !== head_r.status)
						flag_mismatch("status", status, head_r.status);
					if (granted_id !== head_r.granted_id)
						flag_mismatch("granted_id", granted_id, head_r.granted_id);
					if (granted_level !== head_r.granted_level)
						flag_mismatch("granted_level", granted_level, head_r.granted_level);
					if (table_slot !== head_r.table_slot)
						flag_mismatch("table_slot", table_slot, head_r.table_slot);
				end
				n_seen <= n_seen + 1;
			end
			pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("multilevel_slot_queue_scheduler_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned roll;
		int unsigned k;
		bit fill_phase;
		logic [ID_PORT_W-1:0] pid;
		logic [LVL_PORT_W-1:0] lv;

		// Directed: empty dispatch, zero ids, missing id, no-op
		queue_cmd(CMD_DISPATCH, 16'h0000, 2'd0);
		queue_cmd(CMD_ENQUEUE, 16'h0000, 2'd1);
		queue_cmd(CMD_REMOVE, 16'h0000, 2'd0);
		queue_cmd(CMD_REMOVE, 16'hFFFF, 2'd3);
		queue_cmd(CMD_NOP, 16'hA5A5, 2'd3);
		// Priority order and duplicate ids across levels
		queue_cmd(CMD_ENQUEUE, 16'hFFFF, 2'd3);
		queue_cmd(CMD_ENQUEUE, 16'h0001, 2'd0);
		queue_cmd(CMD_ENQUEUE, 16'h1234, 2'd1);
		queue_cmd(CMD_ENQUEUE, 16'h1234, 2'd2);
		queue_cmd(CMD_DISPATCH, 16'hFFFF, 2'd3);
		queue_cmd(CMD_REMOVE, 16'h1234, 2'd0);
		queue_cmd(CMD_DISPATCH, 16'h0000, 2'd0);
		queue_cmd(CMD_DISPATCH, 16'h0000, 2'd0);
		// Fill the table, then overflow it
		for (int i = 0; i < 13; i++)
			queue_cmd(CMD_ENQUEUE, ID_PORT_W'(16'h8000 + i), LVL_PORT_W'(i));
		queue_cmd(CMD_ENQUEUE, 16'h7FFF, 2'd0);

		// Random: alternate filling and draining phases so the table swings both ways
		for (int n = 0; n < RAND_ITEMS; n++) begin
			fill_phase = ((n / 120) % 2) == 1;
			roll = $urandom_range(0, 99);
			lv = LVL_PORT_W'($urandom_range(0, 3));
			if (roll < (fill_phase ? 55 : 20)) begin
				if (live_ids.size() != 0 && $urandom_range(0, 9) == 0)
					pid = live_ids[$urandom_range(0, live_ids.size() - 1)];
				else
					pid = draw_id();
				queue_cmd(CMD_ENQUEUE, pid, lv, (n % 400) == 0);
				if (pid != '0) live_ids.push_back(pid);
				if (live_ids.size() > 40) live_ids.pop_front();
			end else if (roll < (fill_phase ? 75 : 50)) begin
				queue_cmd(CMD_DISPATCH, ID_PORT_W'($urandom_range(0, 65535)), lv, (n % 400) == 0);
			end else if (roll < 95) begin
				if (live_ids.size() != 0 && $urandom_range(0, 9) < 7) begin
					k = $urandom_range(0, live_ids.size() - 1);
					pid = live_ids[k];
					live_ids.delete(k);
				end else begin
					pid = draw_id();
				end
				queue_cmd(CMD_REMOVE, pid, lv, (n % 400) == 0);
			end else begin
				queue_cmd(CMD_NOP, ID_PORT_W'($urandom_range(0, 65535)), lv, (n % 400) == 0);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every beat to go out and every result to come back
		while (cmd_backlog.size() != 0 || push) @(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (results_due.size() != 0) flag_mismatch("missing results", 0, results_due.size());

		if (errors == 0) begin
			$display("multilevel_slot_queue_scheduler_tb: PASS");
		end else begin
			$display("multilevel_slot_queue_scheduler_tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/mlsq_pkg.sv
src/mlsq_front.sv
src/mlsq_back.sv
src/mlsq_resq.sv
src/multilevel_slot_queue_scheduler.sv
tb/sv/multilevel_slot_queue_scheduler_tb.sv
